### rtl/pemd_pkg.sv
`timescale 1ns / 1ps

package pemd_pkg;

  // Fixed field widths
  localparam int SLOT_W  = 12;
  localparam int ALPHA_W = 17;
  localparam int SQ_W    = 49;
  localparam int TOT_W   = 50;
  localparam int ACC_W   = 63;

  // Blend weight: Q1.16, one is 65536, reset is 0.95
  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'd65536;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd62259;

  // Rounding offset for the Q0.16 product (half up)
  localparam int ROUND_HALF = 32768;

  // Saturation limits
  localparam logic [SQ_W-1:0]  SQ_MAX  = {SQ_W{1'b1}};
  localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};
  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

endpackage

### rtl/pemd_in_if.sv
`timescale 1ns / 1ps

interface pemd_in_if
  import pemd_pkg::*;
#(
  parameter int POS_BITS = 24
);
  logic                       valid;
  logic                       ready;
  logic [SLOT_W-1:0]          atom_slot;
  logic signed [POS_BITS-1:0] pos_x;
  logic signed [POS_BITS-1:0] pos_y;
  logic signed [POS_BITS-1:0] pos_z;
  logic                       first_frame;
  logic                       frame_end;

  modport source (
    output valid, atom_slot, pos_x, pos_y, pos_z, first_frame, frame_end,
    input  ready
  );

  modport sink (
    input  valid, atom_slot, pos_x, pos_y, pos_z, first_frame, frame_end,
    output ready
  );
endinterface

### rtl/pemd_out_if.sv
`timescale 1ns / 1ps

interface pemd_out_if
  import pemd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] out_slot;
  logic [SQ_W-1:0]   sq_dev_x;
  logic [SQ_W-1:0]   sq_dev_y;
  logic [SQ_W-1:0]   sq_dev_z;
  logic [TOT_W-1:0]  sq_dev_total;
  logic [ACC_W-1:0]  frame_total;
  logic [ACC_W-1:0]  run_total;
  logic              last_out;

  modport source (
    output valid, out_slot, sq_dev_x, sq_dev_y, sq_dev_z, sq_dev_total,
           frame_total, run_total, last_out,
    input  ready
  );

  modport sink (
    input  valid, out_slot, sq_dev_x, sq_dev_y, sq_dev_z, sq_dev_total,
           frame_total, run_total, last_out,
    output ready
  );
endinterface

### rtl/pemd_ram.sv
`timescale 1ns / 1ps

module pemd_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/position_ema_deviation_top.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Payload
// in_ch     in   valid/ready        atom_slot, pos_x, pos_y, pos_z, first_frame, frame_end
// out_ch    out  valid/ready        out_slot, sq_dev_x/y/z, sq_dev_total, frame_total,
//                                   run_total, last_out
// cfg_*     in   cfg_we (no ready)  cfg_wdata = blend_weight
//
// One item per cycle unless an entry hazard or a stalled output holds the flow; results
// pass the input, memory, product, square, frame sum and output registers. The per-slot
// average memory is read once and written once per item; an item whose entry matches
// one of the two items ahead waits until that write is done, since the read and write-back
// are two stages apart. rst_n clears the pipeline valids and accumulators and reloads the
// blend weight. A stalled output backs up stage by stage; bubbles are squeezed out first.

module position_ema_deviation_top
  import pemd_pkg::*;
#(
  parameter int MAX_ATOMS = 4096,
  parameter int POS_BITS  = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  pemd_in_if.sink            in_ch,
  pemd_out_if.source         out_ch,
  input  logic               cfg_we,
  input  logic [ALPHA_W-1:0] cfg_wdata
);

  localparam int AW      = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int XW      = (AW > SLOT_W) ? AW : SLOT_W;
  localparam int RECIP_W = 25;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((2**24 + MAX_ATOMS - 1) / MAX_ATOMS);
  localparam int MUL_W   = SLOT_W + RECIP_W;
  localparam int DW      = POS_BITS + 1;
  localparam int SQR_W   = 2 * POS_BITS;
  localparam int CW      = (SQR_W > SQ_W) ? SQR_W : SQ_W;
  localparam int PW      = DW + ALPHA_W + 1;
  localparam int IW      = PW - 16;
  localparam int TSUM_W  = SQ_W + 2;
  localparam int MEM_W   = 3 * POS_BITS;

  // Pipeline control
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic s1_free, s2_free, s3_free, s4_free, s5_free, s6_free;
  logic take2, take3, take4, take5, take6;
  logic in_fire, hazard;

  // Configuration
  logic [ALPHA_W-1:0] blend_r;

  // Stage 1: input register
  logic [SLOT_W-1:0]          slot1_r;
  logic [SLOT_W-1:0]          q1_r;
  logic signed [POS_BITS-1:0] pos1_r [3];
  logic                       first1_r, last1_r;
  logic [MUL_W-1:0]           recip_prod;
  logic [31:0]                qm;
  logic [XW-1:0]              rem;
  logic [AW-1:0]              addr1;

  // Stage 2: memory data
  logic [SLOT_W-1:0]          slot2_r;
  logic [AW-1:0]              addr2_r;
  logic signed [POS_BITS-1:0] pos2_r [3];
  logic                       first2_r, last2_r;
  logic [MEM_W-1:0]           ram_rdata;
  logic signed [POS_BITS-1:0] avg2 [3];
  logic signed [DW-1:0]       d2 [3];
  logic [POS_BITS-1:0]        mag2 [3];
  logic [SQR_W-1:0]           sq2 [3];
  logic signed [PW-1:0]       prod2 [3];
  logic signed [ALPHA_W:0]    alpha_s;

  // Stage 3: products
  logic [SLOT_W-1:0]          slot3_r;
  logic [AW-1:0]              addr3_r;
  logic signed [POS_BITS-1:0] pos3_r [3];
  logic signed [POS_BITS-1:0] avg3_r [3];
  logic [SQR_W-1:0]           sq3_r [3];
  logic signed [PW-1:0]       prod3_r [3];
  logic                       first3_r, last3_r;
  logic signed [PW-1:0]       rnd3 [3];
  logic signed [IW-1:0]       inc3 [3];
  logic signed [IW-1:0]       sum3 [3];
  logic [CW-1:0]              sqx3 [3];
  logic [SQ_W-1:0]            sqs3 [3];
  logic [TSUM_W-1:0]          tsum3;
  logic [TOT_W-1:0]           tot3;
  logic [MEM_W-1:0]           ram_wdata;

  // Stage 4: saturated squares and total
  logic [SLOT_W-1:0] slot4_r;
  logic [SQ_W-1:0]   sq4_r [3];
  logic [TOT_W-1:0]  tot4_r;
  logic              last4_r;
  logic [63:0]       fadd;
  logic [ACC_W-1:0]  fsum;
  logic [ACC_W-1:0]  frame_acc_r;

  // Stage 5: frame sum
  logic [SLOT_W-1:0] slot5_r;
  logic [SQ_W-1:0]   sq5_r [3];
  logic [TOT_W-1:0]  tot5_r;
  logic [ACC_W-1:0]  frame5_r;
  logic              last5_r;
  logic [63:0]       radd;
  logic [ACC_W-1:0]  rsum;
  logic [ACC_W-1:0]  run_acc_r;

  // Stage 6: output register
  logic [SLOT_W-1:0] slot6_r;
  logic [SQ_W-1:0]   sq6_r [3];
  logic [TOT_W-1:0]  tot6_r;
  logic [ACC_W-1:0]  frame6_r;
  logic [ACC_W-1:0]  run6_r;
  logic              last6_r;

  // Advance each stage when the next one is empty or moving; stage 1 also waits on the hazard
  assign s6_free = !v6_r || out_ch.ready;
  assign take6   = v5_r && s6_free;
  assign s5_free = !v5_r || take6;
  assign take5   = v4_r && s5_free;
  assign s4_free = !v4_r || take5;
  assign take4   = v3_r && s4_free;
  assign s3_free = !v3_r || take4;
  assign take3   = v2_r && s3_free;
  assign s2_free = !v2_r || take3;
  assign take2   = v1_r && s2_free && !hazard;
  assign s1_free = !v1_r || take2;

  assign in_ch.ready = s1_free;
  assign in_fire     = in_ch.valid && s1_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (s1_free) v1_r <= in_ch.valid;
      if (s2_free) v2_r <= take2;
      if (s3_free) v3_r <= v2_r;
      if (s4_free) v4_r <= v3_r;
      if (s5_free) v5_r <= v4_r;
      if (s6_free) v6_r <= v5_r;
    end
  end

  // Saturate the blend weight at one on write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blend_r <= ALPHA_RESET;
    end else if (cfg_we) begin
      blend_r <= (cfg_wdata > ALPHA_ONE) ? ALPHA_ONE : cfg_wdata;
    end
  end

  // Slot quotient by reciprocal multiply; exact for 12-bit slots
  assign recip_prod = MUL_W'(in_ch.atom_slot) * MUL_W'(RECIP);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      slot1_r   <= in_ch.atom_slot;
      q1_r      <= recip_prod[24 +: SLOT_W];
      pos1_r[0] <= in_ch.pos_x;
      pos1_r[1] <= in_ch.pos_y;
      pos1_r[2] <= in_ch.pos_z;
      first1_r  <= in_ch.first_frame;
      last1_r   <= in_ch.frame_end;
    end
  end

  // Wrap slot into the store and hold it while an earlier item owns the entry
  assign qm     = 32'(q1_r) * 32'(MAX_ATOMS);
  assign rem    = XW'(slot1_r) - XW'(qm);
  assign addr1  = rem[AW-1:0];
  assign hazard = (v2_r && (addr2_r == addr1)) || (v3_r && (addr3_r == addr1));

  pemd_ram #(
    .WIDTH (MEM_W),
    .DEPTH (MAX_ATOMS)
  ) u_avg_ram (
    .clk   (clk),
    .we    (take4),
    .waddr (addr3_r),
    .wdata (ram_wdata),
    .re    (take2),
    .raddr (addr1),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (take2) begin
      slot2_r  <= slot1_r;
      addr2_r  <= addr1;
      pos2_r   <= pos1_r;
      first2_r <= first1_r;
      last2_r  <= last1_r;
    end
  end

  // Deviation, its square and the weighted step
  assign alpha_s = {1'b0, blend_r};

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      avg2[a]  = ram_rdata[a*POS_BITS +: POS_BITS];
      d2[a]    = {pos2_r[a][POS_BITS-1], pos2_r[a]} - {avg2[a][POS_BITS-1], avg2[a]};
      mag2[a]  = d2[a][DW-1] ? POS_BITS'(-d2[a]) : POS_BITS'(d2[a]);
      sq2[a]   = SQR_W'(mag2[a]) * SQR_W'(mag2[a]);
      prod2[a] = PW'(d2[a]) * PW'(alpha_s);
    end
  end

  always_ff @(posedge clk) begin
    if (take3) begin
      slot3_r  <= slot2_r;
      addr3_r  <= addr2_r;
      pos3_r   <= pos2_r;
      avg3_r   <= avg2;
      sq3_r    <= sq2;
      prod3_r  <= prod2;
      first3_r <= first2_r;
      last3_r  <= last2_r;
    end
  end

  // New average (round half up), saturated squares and their sum
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      rnd3[a] = prod3_r[a] + PW'(ROUND_HALF);
      inc3[a] = rnd3[a][PW-1:16];
      sum3[a] = IW'(avg3_r[a]) + inc3[a];
      ram_wdata[a*POS_BITS +: POS_BITS] = first3_r ? pos3_r[a] : sum3[a][POS_BITS-1:0];
      sqx3[a] = CW'(sq3_r[a]);
      if (first3_r) begin
        sqs3[a] = '0;
      end else if (sqx3[a] > CW'(SQ_MAX)) begin
        sqs3[a] = SQ_MAX;
      end else begin
        sqs3[a] = sqx3[a][SQ_W-1:0];
      end
    end
    tsum3 = TSUM_W'(sqs3[0]) + TSUM_W'(sqs3[1]) + TSUM_W'(sqs3[2]);
    tot3  = (tsum3 > TSUM_W'(TOT_MAX)) ? TOT_MAX : tsum3[TOT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (take4) begin
      slot4_r <= slot3_r;
      sq4_r   <= sqs3;
      tot4_r  <= tot3;
      last4_r <= last3_r;
    end
  end

  // Frame accumulator: add, saturate, clear on frame end
  assign fadd = 64'(frame_acc_r) + 64'(tot4_r);
  assign fsum = fadd[63] ? ACC_MAX : fadd[ACC_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_acc_r <= '0;
    end else if (take5) begin
      frame_acc_r <= last4_r ? '0 : fsum;
    end
  end

  always_ff @(posedge clk) begin
    if (take5) begin
      slot5_r  <= slot4_r;
      sq5_r    <= sq4_r;
      tot5_r   <= tot4_r;
      frame5_r <= last4_r ? fsum : '0;
      last5_r  <= last4_r;
    end
  end

  // Run accumulator: frame sum is zero except on frame end
  assign radd = 64'(run_acc_r) + 64'(frame5_r);
  assign rsum = radd[63] ? ACC_MAX : radd[ACC_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_acc_r <= '0;
    end else if (take6) begin
      run_acc_r <= rsum;
    end
  end

  always_ff @(posedge clk) begin
    if (take6) begin
      slot6_r  <= slot5_r;
      sq6_r    <= sq5_r;
      tot6_r   <= tot5_r;
      frame6_r <= frame5_r;
      run6_r   <= rsum;
      last6_r  <= last5_r;
    end
  end

  // Drive the result channel
  assign out_ch.valid        = v6_r;
  assign out_ch.out_slot     = slot6_r;
  assign out_ch.sq_dev_x     = sq6_r[0];
  assign out_ch.sq_dev_y     = sq6_r[1];
  assign out_ch.sq_dev_z     = sq6_r[2];
  assign out_ch.sq_dev_total = tot6_r;
  assign out_ch.frame_total  = frame6_r;
  assign out_ch.run_total    = run6_r;
  assign out_ch.last_out     = last6_r;

`ifndef SYNTHESIS
  // The interlock keeps a read off the entry being written back
  a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
    (take2 && take4) |-> (addr1 != addr3_r))
    else $error("average read and write-back hit the same entry");

  // Frame total shows only on the closing result
  a_frame_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (v6_r && !last6_r) |-> (frame6_r == '0))
    else $error("frame total nonzero on a result that does not close a frame");

  // A frame end clears the frame accumulator
  a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (take5 && last4_r) |=> (frame_acc_r == '0))
    else $error("frame accumulator not cleared after frame end");

  // The run total never goes down
  a_run_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (run_acc_r >= $past(run_acc_r)))
    else $error("run accumulator decreased");
`endif

endmodule

### tb/pemd_checker.sv
`timescale 1ns / 1ps

module pemd_checker
  import pemd_pkg::*;
#(
  parameter int MAX_ATOMS = 4096,
  parameter int POS_BITS  = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  pemd_in_if                 in_mon,
  pemd_out_if                out_mon,
  input  logic               cfg_we,
  input  logic [ALPHA_W-1:0] cfg_wdata,
  output int                 errors,
  output int                 pending
);

  typedef struct {
    logic [SLOT_W-1:0] slot;
    logic [SQ_W-1:0]   sq_x;
    logic [SQ_W-1:0]   sq_y;
    logic [SQ_W-1:0]   sq_z;
    logic [TOT_W-1:0]  sq_sum;
    logic [ACC_W-1:0]  frame_total;
    logic [ACC_W-1:0]  run_total;
    logic              last;
  } deviation_t;

  // Shadow of the per-slot averages, accumulators and blend weight
  logic signed [POS_BITS-1:0] avg_pos [MAX_ATOMS][3];
  logic [ACC_W-1:0]           frame_sum;
  logic [ACC_W-1:0]           run_sum;
  logic [ALPHA_W-1:0]         weight;
  deviation_t                 expected_devs [$];
  int                         mismatches = 0;

  function automatic logic [ACC_W-1:0] add_clamped(input logic [ACC_W-1:0] a,
                                                   input logic [ACC_W-1:0] b);
    logic [ACC_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ACC_W] ? ACC_MAX : s[ACC_W-1:0];
  endfunction

  // Compute the result of one atom transfer and advance the shadow state
  function automatic deviation_t predict_deviation(input logic [SLOT_W-1:0] slot,
                                                   input logic [POS_BITS-1:0] x,
                                                   input logic [POS_BITS-1:0] y,
                                                   input logic [POS_BITS-1:0] z,
                                                   input logic first,
                                                   input logic last);
    deviation_t                r;
    logic [POS_BITS-1:0]       raw [3];
    longint                    coord, centre, d, mag, alpha;
    longint unsigned           sq [3];
    longint unsigned           tot;
    int                        idx;
    raw   = '{x, y, z};
    idx   = int'(slot) % MAX_ATOMS;
    alpha = (weight > ALPHA_ONE) ? ALPHA_ONE : weight;
    tot   = 0;
    for (int a = 0; a < 3; a++) begin
      coord = signed'(raw[a]);
      if (first) begin
        avg_pos[idx][a] = raw[a];
        sq[a] = 0;
      end else begin
        centre = avg_pos[idx][a];
        d      = coord - centre;
        mag    = (d < 0) ? -d : d;
        sq[a]  = mag * mag;
        if (sq[a] > SQ_MAX) sq[a] = SQ_MAX;
        // floor of the rounded Q0.16 product
        avg_pos[idx][a] = POS_BITS'(centre + ((d * alpha + ROUND_HALF) >>> 16));
      end
      tot += sq[a];
    end
    if (tot > TOT_MAX) tot = TOT_MAX;
    frame_sum = add_clamped(frame_sum, ACC_W'(tot));

    r.slot   = slot;
    r.sq_x   = SQ_W'(sq[0]);
    r.sq_y   = SQ_W'(sq[1]);
    r.sq_z   = SQ_W'(sq[2]);
    r.sq_sum = TOT_W'(tot);
    r.last   = last;
    // Close the frame: fold into the run total, then clear
    if (last) begin
      run_sum       = add_clamped(run_sum, frame_sum);
      r.frame_total = frame_sum;
      frame_sum     = '0;
    end else begin
      r.frame_total = '0;
    end
    r.run_total = run_sum;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [SLOT_W-1:0] slot,
                                      input logic [ACC_W-1:0] want,
                                      input logic [ACC_W-1:0] got);
    if (want !== got) begin
      $display("%0t: slot %0d %s mismatch, expected %h, actual %h",
               $time, slot, name, want, got);
      mismatches++;
    end
  endfunction

  // Predict on input transfers, compare on output transfers
  always @(posedge clk) begin
    deviation_t head;
    deviation_t pred;
    if (!rst_n) begin
      weight    = ALPHA_RESET;
      frame_sum = '0;
      run_sum   = '0;
      expected_devs.delete();
    end else begin
      if (cfg_we) weight = cfg_wdata;
      if (in_mon.valid && in_mon.ready) begin
        pred = predict_deviation(in_mon.atom_slot, in_mon.pos_x,
                                 in_mon.pos_y, in_mon.pos_z,
                                 in_mon.first_frame,
                                 in_mon.frame_end);
        expected_devs = {expected_devs, pred};
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_devs.size() == 0) begin
          $display("%0t: result for slot %0d with none expected, expected nothing, actual %h",
                   $time, out_mon.out_slot, out_mon.sq_dev_total);
          mismatches++;
        end else begin
          head = expected_devs.pop_front();
          check_field("out_slot", head.slot, head.slot, out_mon.out_slot);
          check_field("sq_dev_x", head.slot, head.sq_x, out_mon.sq_dev_x);
          check_field("sq_dev_y", head.slot, head.sq_y, out_mon.sq_dev_y);
          check_field("sq_dev_z", head.slot, head.sq_z, out_mon.sq_dev_z);
          check_field("sq_dev_total", head.slot, head.sq_sum, out_mon.sq_dev_total);
          check_field("frame_total", head.slot, head.frame_total, out_mon.frame_total);
          check_field("run_total", head.slot, head.run_total, out_mon.run_total);
          check_field("last_out", head.slot, head.last, out_mon.last_out);
        end
      end
    end
    pending <= expected_devs.size();
    errors  <= mismatches;
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import pemd_pkg::*;

  localparam int N_SLOTS = 4096;
  localparam int POS_W   = 24;

  localparam logic [POS_W-1:0] POS_MAX  = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic [POS_W-1:0] POS_MIN  = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic [POS_W-1:0] POS_ZERO = '0;
  localparam logic [POS_W-1:0] POS_NEG1 = '1;
  localparam logic [ALPHA_W-1:0] WEIGHT_ALL_ONES = '1;

  typedef enum int {ALWAYS_READY, SPARSE_STALL, MASK_STALL, COIN_STALL} stall_mode_e;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [ALPHA_W-1:0] cfg_wdata;
  int                 fail_count;
  int                 pending_count;

  // Sender bookkeeping: which slots hold an average, and a home position per slot
  bit                 slot_seeded [N_SLOTS];
  logic [POS_W-1:0]   home_pos [N_SLOTS][3];
  logic [SLOT_W-1:0]  atom_set [$];
  int                 burst_left;

  pemd_in_if #(.POS_BITS(POS_W)) in_ch ();
  pemd_out_if                    out_ch ();

  position_ema_deviation_top #(
    .MAX_ATOMS(N_SLOTS),
    .POS_BITS (POS_W)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  pemd_checker #(
    .MAX_ATOMS(N_SLOTS),
    .POS_BITS (POS_W)
  ) u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_mon   (in_ch),
    .out_mon  (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .errors   (fail_count),
    .pending  (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Drive ready from a stall mode and mask that are re-picked at random
  initial begin
    int          cyc;
    stall_mode_e mode;
    logic [15:0] stall_mask;
    out_ch.ready <= 1'b0;
    cyc        = 0;
    mode       = ALWAYS_READY;
    stall_mask = '1;
    forever begin
      @(posedge clk);
      if (cyc % 256 == 0) begin
        mode       = stall_mode_e'($urandom_range(0, 3));
        stall_mask = 16'($urandom) | 16'h0001;
      end
      case (mode)
        ALWAYS_READY: begin
          out_ch.ready <= 1'b1;
        end
        SPARSE_STALL: begin
          out_ch.ready <= ($urandom_range(0, 3) != 0);
        end
        MASK_STALL: begin
          out_ch.ready <= stall_mask[cyc % 16];
        end
        default: begin
          out_ch.ready <= 1'($urandom_range(0, 1));
        end
      endcase
      cyc++;
    end
  end

  // Present one atom and hold it until the transfer; insert gaps between bursts
  task automatic send_atom(input logic [SLOT_W-1:0] slot, input logic [POS_W-1:0] x,
                           input logic [POS_W-1:0] y, input logic [POS_W-1:0] z,
                           input logic first, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    // an unloaded slot must be loaded before it is compared
    if (!slot_seeded[slot]) first = 1'b1;
    if (first) slot_seeded[slot] = 1'b1;
    in_ch.valid       <= 1'b1;
    in_ch.atom_slot   <= slot;
    in_ch.pos_x       <= x;
    in_ch.pos_y       <= y;
    in_ch.pos_z       <= z;
    in_ch.first_frame <= first;
    in_ch.frame_end   <= last;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
  endtask

  // Hold input until every result is back, then let the pipeline settle
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_count != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_weight(input logic [ALPHA_W-1:0] w);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly small motion around home, sometimes full-range jumps or extremes
  function automatic logic [POS_W-1:0] rand_coord(input logic [SLOT_W-1:0] slot,
                                                  input int axis);
    logic [POS_W-1:0] jitter;
    jitter = POS_W'($urandom_range(0, 2047));
    case ($urandom_range(0, 11))
      0:       return POS_W'($urandom);
      1:       return POS_MAX;
      2:       return POS_MIN;
      3:       return $urandom_range(0, 1) ? POS_ZERO : POS_NEG1;
      default: return home_pos[slot][axis] + jitter - POS_W'(1024);
    endcase
  endfunction

  task automatic directed_items();
    // load extremes in a first frame
    send_atom(12'd0,    POS_MAX,  POS_MIN,  POS_ZERO, 1'b1, 1'b0);
    send_atom(12'd4095, POS_MIN,  POS_MAX,  POS_NEG1, 1'b1, 1'b0);
    send_atom(12'd1,    POS_ZERO, POS_ZERO, POS_ZERO, 1'b1, 1'b0);
    send_atom(12'd2,    POS_NEG1, 24'd1,    POS_MAX,  1'b1, 1'b1);
    // full-swing deviations; reuse a slot back to back and with two items between
    send_atom(12'd0,    POS_MIN,  POS_MAX,  POS_MAX,  1'b0, 1'b0);
    send_atom(12'd4095, POS_MAX,  POS_MIN,  POS_MIN,  1'b0, 1'b0);
    send_atom(12'd4095, POS_MAX,  POS_MIN,  POS_MIN,  1'b0, 1'b0);
    send_atom(12'd0,    POS_MIN,  POS_MAX,  POS_MAX,  1'b0, 1'b0);
    send_atom(12'd1,    POS_ZERO, POS_ZERO, POS_ZERO, 1'b0, 1'b0);
    send_atom(12'd2,    24'd1,    POS_NEG1, POS_ZERO, 1'b0, 1'b1);
    // reload mid-run, then single-item frames back to back
    send_atom(12'd1,    24'd5000, -24'sd5000, 24'd123, 1'b1, 1'b0);
    send_atom(12'd1,    24'd5001, -24'sd4999, 24'd122, 1'b0, 1'b1);
    send_atom(12'd2,    POS_MAX,  POS_MIN,  24'd77,   1'b0, 1'b1);
    // load and close a frame in one item
    send_atom(12'd3000, 24'h5A5A5A, 24'hA5A5A5, 24'h0F0F0F, 1'b1, 1'b1);
    send_atom(12'd3000, 24'hA5A5A5, 24'h5A5A5A, 24'hF0F0F0, 1'b0, 1'b1);
  endtask

  // Whole frames over a random atom set, with repeats, stray items and broken frames
  task automatic run_frames(input int budget, input bit pause_midway);
    int                sent;
    int                n;
    bit                fresh;
    bit                drop_end;
    bit                paused;
    logic [SLOT_W-1:0] s;
    atom_set.delete();
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
    for (int i = 0; i < n; i++) begin
      s = SLOT_W'($urandom);
      atom_set = {atom_set, s};
      for (int a = 0; a < 3; a++) home_pos[s][a] = POS_W'($urandom);
    end
    sent   = 0;
    fresh  = 1'b1;
    paused = 1'b0;
    while (sent < budget) begin
      if ($urandom_range(0, 9) == 0) begin
        s = SLOT_W'($urandom);
        send_atom(s, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        atom_set.shuffle();
        drop_end = ($urandom_range(0, 7) == 0);
        foreach (atom_set[k]) begin
          s = atom_set[k];
          if ($urandom_range(0, 5) == 0) begin
            send_atom(s, rand_coord(s, 0), rand_coord(s, 1), rand_coord(s, 2), fresh, 1'b0);
            sent++;
          end
          send_atom(s, rand_coord(s, 0), rand_coord(s, 1), rand_coord(s, 2), fresh,
                    (k == atom_set.size() - 1) && !drop_end);
          sent++;
          if (pause_midway && !paused && sent >= budget / 2) begin
            wait_idle();
            paused = 1'b1;
          end
        end
        fresh = ($urandom_range(0, 11) == 0);
      end
    end
  endtask

  initial begin
    logic [ALPHA_W-1:0] weight_plan [7];
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.atom_slot   <= '0;
    in_ch.pos_x       <= '0;
    in_ch.pos_y       <= '0;
    in_ch.pos_z       <= '0;
    in_ch.first_frame <= 1'b0;
    in_ch.frame_end   <= 1'b0;
    burst_left = 0;
    weight_plan = '{17'd0, ALPHA_ONE, WEIGHT_ALL_ONES, 17'd1, 17'd0, 17'd32768,
                    ALPHA_RESET};
    weight_plan[4] = ALPHA_W'($urandom_range(0, 2**ALPHA_W - 1));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_items();
    run_frames(160, 1'b0);
    foreach (weight_plan[p]) begin
      set_weight(weight_plan[p]);
      run_frames(135, p == 2);
    end

    // Drain and give the verdict
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
